// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tcmr_pkg.sv -----
// Shared types and constants of the cost matrix reducer.
// No dependencies; used by the top level and its checker.
package tcmr_pkg;

  localparam int          MAX_STOPS_DEF    = 16;
  localparam int          COST_W           = 32;
  localparam logic [31:0] INF_COST         = 32'hFFFF_FFFF;
  localparam logic [4:0]  COUNT_MAX        = 5'd31;
  localparam logic [4:0]  STOP_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_INIT   = 3'd1,
    OP_COMMIT = 3'd2,
    OP_REDUCE = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RSEL,
    S_RMIN,
    S_RSUB,
    S_CSEL,
    S_CSUB
  } state_t;

endpackage

// ----- rtl/core/tsp_cost_matrix_reducer_unit.sv -----
// Top level of the cost matrix reducer: command channel, cost memory and sequencer.
// Depends on tcmr_pkg.
//
// Usage: a command transfer happens at a clock edge with start high and busy low.
// Every command gives one result, shown for one cycle with out_strobe high; the
// receiver cannot stall it. out_committed_count always shows the edge count.
// The stop count register is written through cfg_valid/cfg_ready (ready is
// always high) and should only change while busy is low.
// Short commands: load, initialize, commit, unused opcodes and out-of-range reads
// give their result in the cycle after the transfer and busy stays low, so one
// such command may follow every cycle.
// An in-range read goes busy in the read state. Reduce runs over the single read
// port of the cost memory with a read, modify and write back of each entry: it
// scans each active row for its minimum and subtracts it, then subtracts each
// active column's finite minimum down the active rows, skipping inactive rows
// and columns and columns with an infinite minimum, up to the effective stop count.
// Reset clears the marks, links, edge count and state and sets the stop count
// to 16; the cost memory holds no defined value until it is loaded.
module tsp_cost_matrix_reducer_unit #(
  parameter int MAX_STOPS = tcmr_pkg::MAX_STOPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_row_index,
  input  logic [3:0]  in_column_index,
  input  logic [31:0] in_cost_value,
  output logic        out_strobe,
  output logic [31:0] out_result_value,
  output logic [4:0]  out_committed_count,
  output logic        out_error_flag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_stop_count
);

  localparam int IW    = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;
  localparam int NW    = $clog2(MAX_STOPS + 1);
  localparam int DEPTH = MAX_STOPS * MAX_STOPS;
  localparam int AW    = $clog2(DEPTH);

  tcmr_pkg::state_t state_r, state_nxt;

  logic [4:0]           stop_count_r;
  logic [NW-1:0]        n_eff;
  logic [MAX_STOPS-1:0] row_act_r, row_act_nxt;
  logic [MAX_STOPS-1:0] col_act_r, col_act_nxt;
  logic [IW-1:0]        fwd_r [MAX_STOPS];
  logic [IW-1:0]        fwd_nxt [MAX_STOPS];
  logic [IW-1:0]        bwd_r [MAX_STOPS];
  logic [IW-1:0]        bwd_nxt [MAX_STOPS];
  logic [31:0]          colmin_r [MAX_STOPS];
  logic [31:0]          colmin_nxt [MAX_STOPS];
  logic [4:0]           count_r, count_nxt;
  logic [NW-1:0]        ridx_r, ridx_nxt;
  logic [NW-1:0]        cidx_r, cidx_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 pv_r, pv_nxt;
  logic [IW-1:0]        pidx_r, pidx_nxt;
  logic [31:0]          min_r, min_nxt;
  logic [31:0]          total_r, total_nxt;
  logic                 err_r, err_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [31:0]          res_r, res_nxt;
  logic                 flag_r, flag_nxt;

  // Cost memory ports.
  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic          in_ok;
  logic [IW-1:0] r_in, c_in;
  logic [IW-1:0] commit_u, commit_v;
  logic          rd_is_inf;
  logic [31:0]   row_sub;
  logic          scan_done;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_STOPS) + AW'(c);
  endfunction

  // Effective dimension, clamped to the supported range.
  always_comb begin
    if (stop_count_r < 5'd2) begin
      n_eff = NW'(2);
    end else if (32'(stop_count_r) > 32'(MAX_STOPS)) begin
      n_eff = NW'(MAX_STOPS);
    end else begin
      n_eff = NW'(stop_count_r);
    end
  end

  assign in_ok     = (32'(in_row_index) < 32'(n_eff)) && (32'(in_column_index) < 32'(n_eff));
  assign r_in      = IW'(in_row_index);
  assign c_in      = IW'(in_column_index);
  assign commit_u  = fwd_r[c_in];
  assign commit_v  = bwd_r[r_in];
  assign rd_is_inf = (rd_data_r == tcmr_pkg::INF_COST);
  assign row_sub   = (min_r == tcmr_pkg::INF_COST) ? 32'd0 : min_r;
  assign scan_done = (cnt_r == n_eff) && !pv_r;

  assign busy                = (state_r != tcmr_pkg::S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_strobe          = strobe_r;
  assign out_result_value    = res_r;
  assign out_committed_count = count_r;
  assign out_error_flag      = flag_r;

  // Next state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    row_act_nxt = row_act_r;
    col_act_nxt = col_act_r;
    fwd_nxt     = fwd_r;
    bwd_nxt     = bwd_r;
    colmin_nxt  = colmin_r;
    count_nxt   = count_r;
    ridx_nxt    = ridx_r;
    cidx_nxt    = cidx_r;
    cnt_nxt     = cnt_r;
    pv_nxt      = 1'b0;
    pidx_nxt    = pidx_r;
    min_nxt     = min_r;
    total_nxt   = total_r;
    err_nxt     = err_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    flag_nxt    = flag_r;
    rd_addr     = addr_of(r_in, c_in);
    we          = 1'b0;
    waddr       = addr_of(r_in, c_in);
    wdata       = in_cost_value;

    case (state_r)
      tcmr_pkg::S_IDLE: begin
        if (start) begin
          res_nxt  = 32'd0;
          flag_nxt = 1'b0;
          case (in_opcode)
            tcmr_pkg::OP_LOAD: begin
              we         = in_ok;
              strobe_nxt = 1'b1;
            end
            tcmr_pkg::OP_INIT: begin
              row_act_nxt = '1;
              col_act_nxt = '1;
              for (int i = 0; i < MAX_STOPS; i++) begin
                fwd_nxt[i] = IW'(i);
                bwd_nxt[i] = IW'(i);
              end
              count_nxt  = 5'd0;
              strobe_nxt = 1'b1;
            end
            tcmr_pkg::OP_COMMIT: begin
              if (in_ok) begin
                fwd_nxt[commit_v] = commit_u;
                bwd_nxt[commit_u] = commit_v;
                we                = 1'b1;
                waddr             = addr_of(commit_u, commit_v);
                wdata             = tcmr_pkg::INF_COST;
                row_act_nxt[r_in] = 1'b0;
                col_act_nxt[c_in] = 1'b0;
                if (count_r < tcmr_pkg::COUNT_MAX) begin
                  count_nxt = count_r + 5'd1;
                end
              end
              strobe_nxt = 1'b1;
            end
            tcmr_pkg::OP_REDUCE: begin
              state_nxt = tcmr_pkg::S_RSEL;
              ridx_nxt  = '0;
              total_nxt = 32'd0;
              err_nxt   = 1'b0;
              for (int i = 0; i < MAX_STOPS; i++) begin
                colmin_nxt[i] = tcmr_pkg::INF_COST;
              end
            end
            tcmr_pkg::OP_READ: begin
              if (in_ok) begin
                state_nxt = tcmr_pkg::S_READ;
              end else begin
                strobe_nxt = 1'b1;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      // Read data arrives in the cycle after the address.
      tcmr_pkg::S_READ: begin
        strobe_nxt = 1'b1;
        res_nxt    = rd_data_r;
        state_nxt  = tcmr_pkg::S_IDLE;
      end

      // Pick the next active row, or move on to the columns.
      tcmr_pkg::S_RSEL: begin
        if (ridx_r == n_eff) begin
          cidx_nxt  = '0;
          state_nxt = tcmr_pkg::S_CSEL;
        end else if (!row_act_r[ridx_r[IW-1:0]]) begin
          ridx_nxt = ridx_r + NW'(1);
        end else begin
          cnt_nxt   = '0;
          min_nxt   = tcmr_pkg::INF_COST;
          state_nxt = tcmr_pkg::S_RMIN;
        end
      end

      // Row minimum over the active columns.
      tcmr_pkg::S_RMIN: begin
        if (cnt_r < n_eff) begin
          rd_addr  = addr_of(ridx_r[IW-1:0], cnt_r[IW-1:0]);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + NW'(1);
        end
        if (pv_r && col_act_r[pidx_r] && (rd_data_r < min_r)) begin
          min_nxt = rd_data_r;
        end
        if (scan_done) begin
          if (min_r == tcmr_pkg::INF_COST) begin
            err_nxt = 1'b1;
          end
          min_nxt   = row_sub;
          total_nxt = total_r + row_sub;
          cnt_nxt   = '0;
          state_nxt = tcmr_pkg::S_RSUB;
        end
      end

      // Subtract the row minimum and track each column's minimum.
      tcmr_pkg::S_RSUB: begin
        if (cnt_r < n_eff) begin
          rd_addr  = addr_of(ridx_r[IW-1:0], cnt_r[IW-1:0]);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + NW'(1);
        end
        if (pv_r && col_act_r[pidx_r]) begin
          wdata = rd_is_inf ? rd_data_r : (rd_data_r - min_r);
          waddr = addr_of(ridx_r[IW-1:0], pidx_r);
          we    = !rd_is_inf;
          if (wdata < colmin_r[pidx_r]) begin
            colmin_nxt[pidx_r] = wdata;
          end
        end
        if (scan_done) begin
          ridx_nxt  = ridx_r + NW'(1);
          state_nxt = tcmr_pkg::S_RSEL;
        end
      end

      // Pick the next active column with a finite minimum, or finish.
      tcmr_pkg::S_CSEL: begin
        if (cidx_r == n_eff) begin
          strobe_nxt = 1'b1;
          res_nxt    = total_r;
          flag_nxt   = err_r;
          state_nxt  = tcmr_pkg::S_IDLE;
        end else begin
          cidx_nxt = cidx_r + NW'(1);
          if (col_act_r[cidx_r[IW-1:0]]) begin
            if (colmin_r[cidx_r[IW-1:0]] == tcmr_pkg::INF_COST) begin
              err_nxt = 1'b1;
            end else begin
              total_nxt = total_r + colmin_r[cidx_r[IW-1:0]];
              cidx_nxt  = cidx_r;
              cnt_nxt   = '0;
              state_nxt = tcmr_pkg::S_CSUB;
            end
          end
        end
      end

      // Subtract the column minimum down the active rows.
      tcmr_pkg::S_CSUB: begin
        if (cnt_r < n_eff) begin
          rd_addr  = addr_of(cnt_r[IW-1:0], cidx_r[IW-1:0]);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + NW'(1);
        end
        if (pv_r && row_act_r[pidx_r] && !rd_is_inf) begin
          we    = 1'b1;
          waddr = addr_of(pidx_r, cidx_r[IW-1:0]);
          wdata = rd_data_r - colmin_r[cidx_r[IW-1:0]];
        end
        if (scan_done) begin
          cidx_nxt  = cidx_r + NW'(1);
          state_nxt = tcmr_pkg::S_CSEL;
        end
      end

      default: begin
        state_nxt = tcmr_pkg::S_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcmr_pkg::S_IDLE;
      stop_count_r <= tcmr_pkg::STOP_COUNT_RESET;
      row_act_r    <= '1;
      col_act_r    <= '1;
      count_r      <= 5'd0;
      pv_r         <= 1'b0;
      strobe_r     <= 1'b0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        fwd_r[i]    <= IW'(i);
        bwd_r[i]    <= IW'(i);
        colmin_r[i] <= tcmr_pkg::INF_COST;
      end
    end else begin
      state_r   <= state_nxt;
      row_act_r <= row_act_nxt;
      col_act_r <= col_act_nxt;
      count_r   <= count_nxt;
      pv_r      <= pv_nxt;
      strobe_r  <= strobe_nxt;
      fwd_r     <= fwd_nxt;
      bwd_r     <= bwd_nxt;
      colmin_r  <= colmin_nxt;
      if (cfg_valid && cfg_ready) begin
        stop_count_r <= cfg_stop_count;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ridx_r  <= ridx_nxt;
    cidx_r  <= cidx_nxt;
    cnt_r   <= cnt_nxt;
    pidx_r  <= pidx_nxt;
    min_r   <= min_nxt;
    total_r <= total_nxt;
    err_r   <= err_nxt;
    res_r   <= res_nxt;
    flag_r  <= flag_nxt;
  end

  // Cost memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/tcmr_checker.sv -----
// Port-level checker of the cost matrix reducer, bound to the top level.
// Depends on assert_macros.svh and tcmr_pkg.
`include "assert_macros.svh"

module tcmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input logic        out_strobe,
  input logic        out_error_flag,
  input logic [31:0] out_result_value
);

  // A transfer gives a result next cycle or starts a multi-cycle command.
  `ASSERT_NEXT(a_accept_progress, start && !busy, out_strobe || busy, "no progress after transfer")

  // A result ends the command, so the block is free while it is shown.
  `ASSERT_SAME(a_strobe_idle, out_strobe, !busy, "result shown while busy")

  // The block only goes busy because a command was taken.
  `ASSERT_SAME(a_busy_cause, $rose(busy), $past(start), "busy without a command")

  // Short commands never go busy and return a zero value without error.
  `ASSERT_NEXT(a_short_cmd, start && !busy && (in_opcode != tcmr_pkg::OP_READ) &&
    (in_opcode != tcmr_pkg::OP_REDUCE), !busy && out_strobe && !out_error_flag &&
    (out_result_value == 32'd0), "short command stalled")

endmodule

bind tsp_cost_matrix_reducer_unit tcmr_checker u_tcmr_checker (.*);
